FILE: hw/rtl/address_payload_unpacker_defines.svh
// Assertion helpers for the files that check the design; the top level includes them.
`ifndef ADDRESS_PAYLOAD_UNPACKER_DEFINES_SVH
`define ADDRESS_PAYLOAD_UNPACKER_DEFINES_SVH

// Check that a condition holds at every clock edge outside reset.
`define APU_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("apu: invariant violated");

// Check that a condition implies a consequence in the same cycle.
`define APU_ASSERT_IMPLY(label, cond, conseq) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error("apu: implication violated");

`endif

FILE: hw/rtl/apu_pkg.sv
package apu_pkg;

    // Status codes reported with the end of a payload
    localparam logic [2:0] STATUS_OK         = 3'd0;
    localparam logic [2:0] STATUS_PAD_LONG   = 3'd1;
    localparam logic [2:0] STATUS_PAD_NONZERO = 3'd2;
    localparam logic [2:0] STATUS_RESERVED   = 3'd3;
    localparam logic [2:0] STATUS_LENGTH     = 3'd4;

    localparam logic [6:0] BYTES_MAX     = 7'd127;
    localparam logic [6:0] HASH_LEN_BASE = 7'd20;
    localparam logic [3:0] BYTE_BITS     = 4'd8;
    localparam logic [3:0] SYMBOL_BITS   = 4'd5;
    localparam logic [2:0] PAD_LIMIT     = 3'd5;

    typedef struct packed {
        logic [7:0] hash_byte;
        logic       byte_valid;
        logic       end_of_payload;
        logic [2:0] status;
        logic [3:0] addr_type;
        logic [6:0] hash_length;
    } apu_result_t;

    // Expected hash length from the low version bits
    function automatic logic [6:0] hash_len_from_version(input logic [2:0] v);
        logic [6:0] base;
        begin
            base = HASH_LEN_BASE + {3'b000, v[1:0], 2'b00};
            hash_len_from_version = v[2] ? {base[5:0], 1'b0} : base;
        end
    endfunction

endpackage

FILE: hw/rtl/apu_core.sv
module apu_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_fire,
    input  logic [4:0]          symbol,
    input  logic                last_symbol,
    output logic                has_result,
    output apu_pkg::apu_result_t result
);
    import apu_pkg::*;

    logic [11:0] acc_reg;
    logic [11:0] acc_next;
    logic [2:0]  pend_reg;
    logic [2:0]  pend_next;
    logic [6:0]  bytes_reg;
    logic [6:0]  bytes_next;
    logic [7:0]  version_reg;
    logic [7:0]  version_next;

    logic [3:0]  pend_sum;
    logic        form;
    logic        first;
    logic        emit;
    logic [11:0] shifted;
    logic [7:0]  new_byte;
    logic [6:0]  exp_len;
    logic [4:0]  pad_mask;
    logic [2:0]  status_val;

    // Shift the symbol in and form a byte once eight bits are pending
    always_comb
    begin
        acc_next  = {acc_reg[6:0], symbol};
        pend_sum  = {1'b0, pend_reg} + SYMBOL_BITS;
        form      = (pend_sum >= BYTE_BITS);
        pend_next = form ? 3'(pend_sum - BYTE_BITS) : pend_sum[2:0];
        shifted   = acc_next >> pend_next;
        new_byte  = shifted[7:0];
        first     = (bytes_reg == 7'd0);
        emit      = form && !first;
        version_next = (form && first) ? new_byte : version_reg;
        bytes_next   = (form && (bytes_reg != BYTES_MAX)) ? bytes_reg + 7'd1 : bytes_reg;
        exp_len   = hash_len_from_version(version_next[2:0]);
        pad_mask  = (5'd1 << pend_next) - 5'd1;
    end

    // Pick the first failing check at the end of a payload
    always_comb
    begin
        if (pend_next >= PAD_LIMIT)
        begin
            status_val = STATUS_PAD_LONG;
        end
        else if ((acc_next[3:0] & pad_mask[3:0]) != 4'd0)
        begin
            status_val = STATUS_PAD_NONZERO;
        end
        else if (version_next[7])
        begin
            status_val = STATUS_RESERVED;
        end
        else if (bytes_next != exp_len + 7'd1)
        begin
            status_val = STATUS_LENGTH;
        end
        else
        begin
            status_val = STATUS_OK;
        end
    end

    // Build the result word
    always_comb
    begin
        has_result            = emit || last_symbol;
        result.hash_byte      = emit ? new_byte : 8'd0;
        result.byte_valid     = emit;
        result.end_of_payload = last_symbol;
        result.status         = last_symbol ? status_val : STATUS_OK;
        result.addr_type      = last_symbol ? version_next[6:3] : 4'd0;
        result.hash_length    = last_symbol ? exp_len : 7'd0;
    end

    // Advance the state; drop back to the start after the last symbol
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pend_reg    <= '0;
            bytes_reg   <= '0;
            version_reg <= '0;
        end
        else if (in_fire)
        begin
            if (last_symbol)
            begin
                acc_reg     <= '0;
                pend_reg    <= '0;
                bytes_reg   <= '0;
                version_reg <= '0;
            end
            else
            begin
                acc_reg     <= acc_next;
                pend_reg    <= pend_next;
                bytes_reg   <= bytes_next;
                version_reg <= version_next;
            end
        end
    end

endmodule

FILE: hw/rtl/apu_skid.sv
module apu_skid (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  apu_pkg::apu_result_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_ready,
    output apu_pkg::apu_result_t out_data
);
    import apu_pkg::*;

    logic        main_valid_reg;
    logic        main_valid_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    apu_result_t main_reg;
    apu_result_t main_next;
    apu_result_t skid_reg;
    apu_result_t skid_next;
    logic        pop;

    assign pop       = main_valid_reg && out_ready;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Move words between the output slot and the skid slot
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    // Hold valid flags under reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

FILE: hw/rtl/address_payload_unpacker.sv
// Address payload unpacker.
// Input channel: in_valid/in_ready carry one word per symbol: a 5-bit
// symbol and last_symbol marking the final symbol of a payload.
// Output channel: out_valid/out_ready carry result words: hash_byte with
// byte_valid for each hash byte formed, and on the last symbol
// end_of_payload with status, addr_type and hash_length.
// The first byte formed is the version byte and yields no word by itself;
// a symbol that neither forms a hash byte nor ends the payload yields none.
// A result word is registered into the output register when its symbol is taken,
// or into the skid slot while the output register holds an untaken word. Throughput: one symbol per
// cycle while in_ready is high, set by the combinational regroup logic in front of the output register.
// Stall: a two-entry output buffer (output register plus skid slot) keeps
// taking symbols while one word waits; in_ready drops only when both are
// occupied, and rises again once the receiver takes a word.
// Reset: rst_n clears the regroup state and empties the output buffer;
// the state also returns to its start after every last symbol.
`include "address_payload_unpacker_defines.svh"

module address_payload_unpacker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [4:0] symbol,
    input  logic       last_symbol,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] hash_byte,
    output logic       byte_valid,
    output logic       end_of_payload,
    output logic [2:0] status,
    output logic [3:0] addr_type,
    output logic [6:0] hash_length
);
    import apu_pkg::*;

    logic        in_fire;
    logic        has_result;
    logic        buf_full;
    apu_result_t core_result;
    apu_result_t out_word;

    assign in_ready = !buf_full;
    assign in_fire  = in_valid && in_ready;

    apu_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .symbol      (symbol),
        .last_symbol (last_symbol),
        .has_result  (has_result),
        .result      (core_result)
    );

    apu_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_fire && has_result),
        .push_data (core_result),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_word)
    );

    // Unpack the output word onto the ports
    assign hash_byte      = out_word.hash_byte;
    assign byte_valid     = out_word.byte_valid;
    assign end_of_payload = out_word.end_of_payload;
    assign status         = out_word.status;
    assign addr_type      = out_word.addr_type;
    assign hash_length    = out_word.hash_length;

    `APU_ASSERT_IMPLY(a_stall_needs_word, !in_ready, out_valid)
    `APU_ASSERT_IMPLY(a_word_has_content, out_valid, byte_valid || end_of_payload)
    `APU_ASSERT_IMPLY(a_status_only_at_end, out_valid && !end_of_payload,
                      status == STATUS_OK && hash_length == 7'd0)

endmodule

FILE: tb/address_payload_unpacker_tb.sv
module address_payload_unpacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apu_pkg::*;

    localparam int RANDOM_SYMBOLS = 1100;
    localparam int IDLE_LIMIT     = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int SHOWN_MAX      = 10;
    localparam int PLAN_ROWS      = 19;

    typedef enum int {
        PL_CLEAN,
        PL_RESERVED,
        PL_LENGTH,
        PL_SATURATE,
        PL_PADDING,
        PL_NOISE
    } payload_kind_t;

    // One row of the directed table; the expected word is filled in only when typed is set
    typedef struct {
        logic [4:0] sym;
        logic       last;
        bit         typed;
        logic [7:0] hbyte;
        logic       bvalid;
        logic [2:0] stat;
        logic [3:0] atype;
        logic [6:0] hlen;
    } plan_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       in_valid    = 1'b0;
    logic       in_ready;
    logic [4:0] symbol      = '0;
    logic       last_symbol = 1'b0;
    logic       out_valid;
    logic       out_ready   = 1'b0;
    logic [7:0] hash_byte;
    logic       byte_valid;
    logic       end_of_payload;
    logic [2:0] status;
    logic [3:0] addr_type;
    logic [6:0] hash_length;

    // Regroup state as the block should hold it
    logic [11:0] acc_bits     = '0;
    logic [2:0]  acc_count    = '0;
    logic [6:0]  formed_bytes = '0;
    logic [7:0]  version_seen = '0;

    apu_result_t expected_words[$];

    int  failures      = 0;
    int  shown         = 0;
    int  words_checked = 0;
    int  symbols_sent  = 0;
    int  payloads      = 0;
    int  status_seen[5];
    bit  steady        = 1'b0;

    plan_row_t directed_plan [PLAN_ROWS] = '{
        // lone symbols: padding too long, reset version byte
        '{5'd0,  1'b1, 1'b1, 8'h00, 1'b0, STATUS_PAD_LONG,    4'd0,  7'd20},
        '{5'd31, 1'b1, 1'b1, 8'h00, 1'b0, STATUS_PAD_LONG,    4'd0,  7'd20},
        // version 0xff with ones in the padding
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b1, 1'b1, 8'h00, 1'b0, STATUS_PAD_NONZERO, 4'd15, 7'd64},
        // version 0x80: reserved bit
        '{5'd16, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd0,  1'b1, 1'b1, 8'h00, 1'b0, STATUS_RESERVED,    4'd0,  7'd20},
        // version 0x00 and nothing else: too short
        '{5'd0,  1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd0,  1'b1, 1'b1, 8'h00, 1'b0, STATUS_LENGTH,      4'd0,  7'd20},
        // fifteen bits: seven left over
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b1, 1'b1, 8'h00, 1'b0, STATUS_PAD_LONG,    4'd15, 7'd64},
        // last symbol forms a hash byte
        '{5'd0,  1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd0,  1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd16, 1'b1, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        // all ones: hash byte 0xff shares the word with the end report
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b0, 1'b0, 8'h00, 1'b0, STATUS_OK,          4'd0,  7'd0},
        '{5'd31, 1'b1, 1'b1, 8'hff, 1'b1, STATUS_PAD_NONZERO, 4'd15, 7'd64}
    };

    address_payload_unpacker dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Expected hash bytes encoded in the low three version bits
    function automatic logic [6:0] length_code(input logic [7:0] ver);
        logic [6:0] len;
        begin
            len = 7'd20 + {3'b000, ver[1:0], 2'b00};
            if (ver[2])
                len = {len[5:0], 1'b0};
            return len;
        end
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                return 0;
            else if (r < 90)
                return $urandom_range(1, 3);
            else
                return $urandom_range(8, 30);
        end
    endfunction

    // Shift one symbol into the regroup state and work out the word it causes
    task automatic regroup_symbol(input logic [4:0] s, input logic l,
                                  output bit has_word, output apu_result_t word);
        logic [3:0] total;
        logic [7:0] formed;
        logic [6:0] want_len;
        bit         hash_ready;
        begin
            word       = '0;
            hash_ready = 1'b0;
            acc_bits   = {acc_bits[6:0], s};
            total      = {1'b0, acc_count} + 4'd5;
            if (total >= 4'd8)
            begin
                total  = total - 4'd8;
                formed = 8'(acc_bits >> total);
                // first byte of a payload is the version byte
                if (formed_bytes == 7'd0)
                    version_seen = formed;
                else
                begin
                    hash_ready      = 1'b1;
                    word.hash_byte  = formed;
                    word.byte_valid = 1'b1;
                end
                if (formed_bytes != BYTES_MAX)
                    formed_bytes = formed_bytes + 7'd1;
            end
            acc_count = total[2:0];

            // report on the last symbol, then start over
            if (l)
            begin
                want_len            = length_code(version_seen);
                word.end_of_payload = 1'b1;
                word.addr_type      = version_seen[6:3];
                word.hash_length    = want_len;
                if (acc_count >= PAD_LIMIT)
                    word.status = STATUS_PAD_LONG;
                else if ((acc_bits & ((12'd1 << acc_count) - 12'd1)) != 12'd0)
                    word.status = STATUS_PAD_NONZERO;
                else if (version_seen[7])
                    word.status = STATUS_RESERVED;
                else if (formed_bytes != want_len + 7'd1)
                    word.status = STATUS_LENGTH;
                else
                    word.status = STATUS_OK;
                status_seen[word.status]++;
                acc_bits     = '0;
                acc_count    = '0;
                formed_bytes = '0;
                version_seen = '0;
            end
            has_word = hash_ready || l;
        end
    endtask

    // Offer one symbol word, wait for it to be taken, and queue its result
    task automatic send_symbol(input logic [4:0] s, input logic l, input bit typed,
                               input apu_result_t typed_word);
        int          gap;
        bit          has_word;
        apu_result_t word;
        begin
            gap = steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            in_valid    <= 1'b1;
            symbol      <= s;
            last_symbol <= l;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            regroup_symbol(s, l, has_word, word);
            if (typed)
                word = typed_word;
            if (has_word || typed)
                expected_words.push_back(word);
            symbols_sent++;
        end
    endtask

    // Build one payload of the given kind as a bit stream and send it as symbols
    task automatic send_payload(input payload_kind_t kind);
        bit          stream[$];
        logic [7:0]  ver;
        logic [7:0]  byte_val;
        logic [6:0]  len;
        logic [3:0]  pad_val;
        logic [4:0]  s;
        int          n_bytes;
        int          n_syms;
        int          pad;
        apu_result_t none;
        begin
            none   = '0;
            steady = ($urandom_range(0, 4) == 0);
            payloads++;
            if (kind == PL_NOISE)
            begin
                n_syms = $urandom_range(1, 12);
                for (int i = 0; i < n_syms; i++)
                    send_symbol(5'($urandom), i == n_syms - 1, 1'b0, none);
            end
            else
            begin
                ver = 8'($urandom);
                ver[7] = (kind == PL_RESERVED);
                len = length_code(ver);
                n_bytes = len + 1;
                if (kind == PL_LENGTH)
                    n_bytes = $urandom_range(1, len + 6);
                else if (kind == PL_SATURATE)
                    n_bytes = $urandom_range(128, 140);

                for (int b = 0; b < n_bytes; b++)
                begin
                    byte_val = (b == 0) ? ver : 8'($urandom);
                    for (int k = 7; k >= 0; k--)
                        stream.push_back(byte_val[k]);
                end

                // fill up to a whole symbol; corrupt the fill or add a stray symbol
                pad     = (5 - stream.size() % 5) % 5;
                pad_val = '0;
                if (kind == PL_PADDING && pad > 0 && $urandom_range(0, 1) == 1)
                    pad_val = 4'($urandom_range(1, (1 << pad) - 1));
                for (int k = pad - 1; k >= 0; k--)
                    stream.push_back(pad_val[k]);
                if (kind == PL_PADDING && pad_val == 4'd0)
                    for (int k = 0; k < 5; k++)
                        stream.push_back(bit'($urandom_range(0, 1)));

                n_syms = stream.size() / 5;
                for (int i = 0; i < n_syms; i++)
                begin
                    s = {stream[5*i], stream[5*i+1], stream[5*i+2],
                         stream[5*i+3], stream[5*i+4]};
                    send_symbol(s, i == n_syms - 1, 1'b0, none);
                end
            end
        end
    endtask

    // Compare a taken result word with the oldest expectation
    task automatic check_word(input apu_result_t got);
        apu_result_t want;
        begin
            if (expected_words.size() == 0)
            begin
                failures++;
                if (shown < SHOWN_MAX)
                begin
                    shown++;
                    $display("%0t: unexpected word byte=%02h bv=%0b end=%0b",
                             $realtime, got.hash_byte, got.byte_valid, got.end_of_payload);
                    $display("%0t:          st=%0d type=%0d len=%0d",
                             $realtime, got.status, got.addr_type, got.hash_length);
                end
            end
            else
            begin
                want = expected_words.pop_front();
                words_checked++;
                if (got.hash_byte !== want.hash_byte || got.byte_valid !== want.byte_valid
                    || got.end_of_payload !== want.end_of_payload
                    || got.status !== want.status || got.addr_type !== want.addr_type
                    || got.hash_length !== want.hash_length)
                begin
                    failures++;
                    if (shown < SHOWN_MAX)
                    begin
                        shown++;
                        $display({"%0t: mismatch exp byte=%02h bv=%0b end=%0b",
                                  " st=%0d type=%0d len=%0d"},
                                 $realtime, want.hash_byte, want.byte_valid,
                                 want.end_of_payload, want.status, want.addr_type,
                                 want.hash_length);
                        $display({"%0t:          got byte=%02h bv=%0b end=%0b",
                                  " st=%0d type=%0d len=%0d"},
                                 $realtime, got.hash_byte, got.byte_valid,
                                 got.end_of_payload, got.status, got.addr_type,
                                 got.hash_length);
                    end
                end
            end
        end
    endtask

    // Check every result word as it is taken
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            check_word({hash_byte, byte_valid, end_of_payload, status, addr_type,
                        hash_length});
    end

    // Throttle the receiver: ready runs of random length, some long, between stalls
    initial
    begin
        int run;
        int hold;
        @(posedge rst_n);
        forever
        begin
            run = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
            @(negedge clk);
            out_ready <= 1'b1;
            repeat (run - 1) @(negedge clk);
            hold = pick_gap();
            if (hold > 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (hold - 1) @(negedge clk);
            end
        end
    end

    // End the run when no word moves on either side for too long
    initial
    begin
        int idle;
        idle = 0;
        @(posedge rst_n);
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("watchdog: no word moved for %0d cycles, %0d still expected",
                 IDLE_LIMIT, expected_words.size());
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        apu_result_t   typed_word;
        payload_kind_t kind;
        int            pick;
        int            random_start;
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (directed_plan[i])
        begin
            typed_word = {directed_plan[i].hbyte, directed_plan[i].bvalid,
                          directed_plan[i].last, directed_plan[i].stat,
                          directed_plan[i].atype, directed_plan[i].hlen};
            send_symbol(directed_plan[i].sym, directed_plan[i].last,
                        directed_plan[i].typed, typed_word);
        end

        // random payloads, well formed or with faults; start with one that saturates the count
        random_start = symbols_sent;
        kind = PL_SATURATE;
        while (symbols_sent - random_start < RANDOM_SYMBOLS)
        begin
            send_payload(kind);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                kind = PL_CLEAN;
            else if (pick < 50)
                kind = PL_RESERVED;
            else if (pick < 65)
                kind = PL_LENGTH;
            else if (pick < 67)
                kind = PL_SATURATE;
            else if (pick < 78)
                kind = PL_PADDING;
            else
                kind = PL_NOISE;
        end

        // drop valid and drain
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d symbols (directed table and %0d random payloads), %0d words checked",
                 symbols_sent, payloads, words_checked);
        $display("end reports ok/pad long/pad nonzero/reserved/length: %0d/%0d/%0d/%0d/%0d",
                 status_seen[STATUS_OK], status_seen[STATUS_PAD_LONG],
                 status_seen[STATUS_PAD_NONZERO], status_seen[STATUS_RESERVED],
                 status_seen[STATUS_LENGTH]);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/apu_pkg.sv
hw/rtl/apu_core.sv
hw/rtl/apu_skid.sv
hw/rtl/address_payload_unpacker.sv
tb/address_payload_unpacker_tb.sv
